@@ design/sdtq_pkg.sv @@
package sdtq_pkg;

    typedef enum logic [2:0] {
        FN_SET_REAL  = 3'd0,
        FN_SET_VIRT  = 3'd1,
        FN_CANCEL    = 3'd2,
        FN_QUERY     = 3'd3,
        FN_SEC_TICK  = 3'd4,
        FN_VIRT_TICK = 3'd5
    } t_func;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_VIRT_BUSY = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic KIND_RESP   = 1'b0;
    localparam logic KIND_EXPIRE = 1'b1;

    localparam int REM_BITS = 24;

endpackage

@@ design/sdtq_ram.sv @@
module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/sorted_deadline_timer_queue_top.sv @@
// channel   | direction | handshake          | fields
// command   | in        | start & !busy      | i_func, i_seconds, i_timer_id
// result    | out       | o_valid (1 cycle)  | o_kind, o_status, o_result_id,
//           |           |                    | o_remaining, o_last
// Entries live in one RAM {id, deadline}, sorted, count in r_count; walked one entry at a time.
// Virtual ops, a full set and unused codes go straight to the response strobe; cancel/query
// search the table (cancel then shifts down), set walks, shifts up and runs the expiry check,
// and a second tick may expire the whole table before its response strobe.
// Synchronous active-low reset clears count, time, id counter, virtual timer.
// busy is high from accept until the response strobe cycle; results cannot stall.
module sorted_deadline_timer_queue_top #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [23:0] i_seconds,
    input  logic [15:0] i_timer_id,
    output logic        o_valid,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_id,
    output logic [23:0] o_remaining,
    output logic        o_last
);
    import sdtq_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = ID_BITS + TIME_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_INS_RD, S_INS_CMP, S_SHUP_RD, S_SHUP_WR,
        S_EXP_RD, S_EXP_CHK, S_SHDN_RD, S_SHDN_WR, S_FIND_RD, S_FIND_CMP,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [2:0]          r_func;
    logic [23:0]         r_secs;
    logic [ID_BITS-1:0]  r_tid;
    logic [CW-1:0]       r_count;
    logic [TIME_BITS-1:0] r_now;
    logic [ID_BITS-1:0]  r_idc;
    logic                r_vvalid;
    logic [ID_BITS-1:0]  r_vid;
    logic [23:0]         r_vrem;
    logic [CW-1:0]       r_ptr;
    logic [CW-1:0]       r_pos;
    logic [ID_BITS-1:0]  r_newid;
    logic [TIME_BITS-1:0] r_newdl;
    logic [1:0]          r_rst;
    logic [23:0]         r_rrem;
    logic                r_after_find;

    logic                n_we;
    logic [AW-1:0]       n_waddr;
    logic [EW-1:0]       n_wdata;
    logic [AW-1:0]       n_raddr;
    logic [EW-1:0]       w_rdata;
    logic [ID_BITS-1:0]  w_rid;
    logic [TIME_BITS-1:0] w_rdl;
    logic [TIME_BITS-1:0] w_diff;

    assign w_rid  = w_rdata[EW-1:TIME_BITS];
    assign w_rdl  = w_rdata[TIME_BITS-1:0];
    assign w_diff = w_rdl - r_now;
    assign busy   = (r_state != S_IDLE);

    sdtq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(w_rdata)
    );

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_ptr[AW-1:0];
        n_wdata = '0;
        n_raddr = r_ptr[AW-1:0];
        case (r_state)
            S_SHUP_WR: begin
                n_we    = 1'b1;
                n_waddr = r_ptr[AW-1:0];
                n_wdata = w_rdata;
            end
            S_SHUP_RD: begin
                if (r_ptr == r_pos) begin
                    n_we    = 1'b1;
                    n_waddr = r_pos[AW-1:0];
                    n_wdata = {r_newid, r_newdl};
                end
                n_raddr = AW'(r_ptr - CW'(1));
            end
            S_SHDN_WR: begin
                n_we    = 1'b1;
                n_waddr = AW'(r_ptr - CW'(1));
                n_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        o_last  <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_now    <= '0;
            r_idc    <= '0;
            r_vvalid <= 1'b0;
            r_vid    <= '0;
            r_vrem   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_secs  <= i_seconds;
                        r_tid   <= ID_BITS'(i_timer_id);
                        r_rst   <= ST_OK;
                        r_rrem  <= '0;
                        r_newid <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_ptr <= '0;
                    case (r_func)
                        FN_SET_REAL: begin
                            if (r_count == CW'(SLOTS)) begin
                                r_rst   <= ST_FULL;
                                r_newid <= '1;
                                r_state <= S_RESP;
                            end else begin
                                r_newid <= r_idc;
                                r_idc   <= r_idc + 1'b1;
                                r_newdl <= r_now + TIME_BITS'(r_secs);
                                r_state <= S_INS_RD;
                            end
                        end
                        FN_SET_VIRT: begin
                            if (r_vvalid) begin
                                r_rst   <= ST_VIRT_BUSY;
                                r_newid <= '1;
                            end else begin
                                r_newid <= r_idc;
                                r_idc   <= r_idc + 1'b1;
                                if (r_secs == '0) begin
                                    o_valid     <= 1'b1;
                                    o_kind      <= KIND_EXPIRE;
                                    o_status    <= ST_OK;
                                    o_result_id <= 16'(r_idc);
                                    o_remaining <= '0;
                                end else begin
                                    r_vvalid <= 1'b1;
                                    r_vid    <= r_idc;
                                    r_vrem   <= r_secs;
                                end
                            end
                            r_state <= S_RESP;
                        end
                        FN_CANCEL, FN_QUERY: begin
                            if (r_vvalid && r_vid == r_tid) begin
                                if (r_func == FN_CANCEL) begin
                                    r_vvalid <= 1'b0;
                                    r_vrem   <= '0;
                                end else begin
                                    r_rrem <= r_vrem;
                                end
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_FIND_RD;
                            end
                        end
                        FN_SEC_TICK: begin
                            r_now   <= r_now + 1'b1;
                            r_state <= S_EXP_RD;
                        end
                        FN_VIRT_TICK: begin
                            if (r_vvalid) begin
                                r_vrem <= r_vrem - 1'b1;
                                if (r_vrem == 24'd1) begin
                                    r_vvalid    <= 1'b0;
                                    o_valid     <= 1'b1;
                                    o_kind      <= KIND_EXPIRE;
                                    o_status    <= ST_OK;
                                    o_result_id <= 16'(r_vid);
                                    o_remaining <= '0;
                                end
                            end
                            r_state <= S_RESP;
                        end
                        default: r_state <= S_RESP;
                    endcase
                end
                S_INS_RD: begin
                    if (r_ptr == r_count) begin
                        r_pos   <= r_ptr;
                        r_state <= S_SHUP_RD;
                        r_ptr   <= r_count;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_rdl <= r_newdl) begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_pos   <= r_ptr;
                        r_ptr   <= r_count;
                        r_state <= S_SHUP_RD;
                    end
                end
                S_SHUP_RD: begin
                    if (r_ptr == r_pos) begin
                        r_count <= r_count + 1'b1;
                        r_ptr   <= '0;
                        r_state <= S_EXP_RD;
                    end else begin
                        r_state <= S_SHUP_WR;
                    end
                end
                S_SHUP_WR: begin
                    r_ptr   <= r_ptr - 1'b1;
                    r_state <= S_SHUP_RD;
                end
                S_EXP_RD: begin
                    r_ptr   <= '0;
                    r_state <= (r_count == '0) ? S_RESP : S_EXP_CHK;
                end
                S_EXP_CHK: begin
                    if (w_rdl <= r_now) begin
                        o_valid     <= 1'b1;
                        o_kind      <= KIND_EXPIRE;
                        o_status    <= ST_OK;
                        o_result_id <= 16'(w_rid);
                        o_remaining <= '0;
                        r_after_find <= 1'b0;
                        r_ptr   <= CW'(1);
                        r_state <= S_SHDN_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_SHDN_RD: begin
                    if (r_ptr == r_count) begin
                        r_count <= r_count - 1'b1;
                        r_ptr   <= '0;
                        r_state <= r_after_find ? S_RESP : S_EXP_RD;
                    end else begin
                        r_state <= S_SHDN_WR;
                    end
                end
                S_SHDN_WR: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_SHDN_RD;
                end
                S_FIND_RD: begin
                    if (r_ptr == r_count) begin
                        r_rst   <= ST_NOT_FOUND;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_FIND_CMP;
                    end
                end
                S_FIND_CMP: begin
                    if (w_rid == r_tid) begin
                        if (r_func == FN_CANCEL) begin
                            r_after_find <= 1'b1;
                            r_ptr   <= r_ptr + 1'b1;
                            r_state <= S_SHDN_RD;
                        end else begin
                            if (w_rdl > r_now) begin
                                r_rrem <= (w_diff > TIME_BITS'(24'hFFFFFF)) ?
                                          24'hFFFFFF : 24'(w_diff);
                            end
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_FIND_RD;
                    end
                end
                S_RESP: begin
                    o_valid     <= 1'b1;
                    o_last      <= 1'b1;
                    o_kind      <= KIND_RESP;
                    o_status    <= r_rst;
                    o_result_id <= (r_rst == ST_FULL || r_rst == ST_VIRT_BUSY) ?
                                   16'(r_newid) :
                                   ((r_func == FN_SET_REAL || r_func == FN_SET_VIRT) ?
                                    16'(r_newid) : 16'd0);
                    o_remaining <= r_rrem;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS)) else $error("count over capacity");
    a_last_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind == KIND_RESP) else $error("last on expiry");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy) else $error("busy after last");
`endif
endmodule

@@ verif/tb_sorted_deadline_timer_queue_top.sv @@
module tb_sorted_deadline_timer_queue_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sdtq_pkg::*;

    localparam int NSLOT = 16;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [2:0]  func;
        logic [23:0] seconds;
        logic [15:0] tid;
        bit          drain;
    } cmd_t;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] rid;
        logic [23:0] rem;
        logic        last;
    } res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [23:0] i_seconds = '0;
    logic [15:0] i_timer_id = '0;
    logic        o_valid, o_kind, o_last;
    logic [1:0]  o_status;
    logic [15:0] o_result_id;
    logic [23:0] o_remaining;

    sorted_deadline_timer_queue_top DUT (.*);

    always #5 i_clk = ~i_clk;

    cmd_t cmd_q[$];
    res_t exp_q[$];
    int   errors = 0;
    int   cycles = 0;
    int   n_accepted = 0;
    int   n_expiries = 0;
    int   n_full = 0;
    int   n_busy = 0;
    bit   gen_done = 0;
    bit   taken = 0;

    // timer table shadow
    bit          tq_valid[NSLOT];
    logic [15:0] tq_id[NSLOT];
    logic [31:0] tq_dl[NSLOT];
    logic [31:0] now_sec;
    logic [15:0] next_id;
    bit          vt_valid;
    logic [15:0] vt_id;
    logic [23:0] vt_rem;

    function automatic void push_res(logic k, logic [1:0] st, logic [15:0] id,
                                     logic [23:0] rm, logic l);
        res_t r;
        r.kind = k; r.status = st; r.rid = id; r.rem = rm; r.last = l;
        exp_q.push_back(r);
        if (k == KIND_EXPIRE) n_expiries++;
    endfunction

    function automatic void drop_slot(int p);
        for (int i = p; i < NSLOT - 1; i++) begin
            tq_valid[i] = tq_valid[i+1];
            tq_id[i] = tq_id[i+1];
            tq_dl[i] = tq_dl[i+1];
        end
        tq_valid[NSLOT-1] = 0;
    endfunction

    function automatic void expire_due();
        while (tq_valid[0] && tq_dl[0] <= now_sec) begin
            push_res(KIND_EXPIRE, ST_OK, tq_id[0], '0, 1'b0);
            drop_slot(0);
        end
    endfunction

    function automatic void predict_timers(cmd_t c);
        int          pos;
        bit          hit;
        logic [15:0] id;
        logic [31:0] dl;
        logic [23:0] rm;
        hit = 0;
        rm = '0;
        case (c.func)
            FN_SET_REAL: begin
                if (tq_valid[NSLOT-1]) begin
                    n_full++;
                    push_res(KIND_RESP, ST_FULL, 16'hFFFF, '0, 1'b1);
                end else begin
                    id = next_id;
                    next_id++;
                    dl = now_sec + 32'(c.seconds);
                    pos = 0;
                    while (pos < NSLOT && tq_valid[pos] && tq_dl[pos] <= dl) pos++;
                    for (int i = NSLOT - 1; i > pos; i--) begin
                        tq_valid[i] = tq_valid[i-1];
                        tq_id[i] = tq_id[i-1];
                        tq_dl[i] = tq_dl[i-1];
                    end
                    tq_valid[pos] = 1;
                    tq_id[pos] = id;
                    tq_dl[pos] = dl;
                    expire_due();
                    push_res(KIND_RESP, ST_OK, id, '0, 1'b1);
                end
            end
            FN_SET_VIRT: begin
                if (vt_valid) begin
                    n_busy++;
                    push_res(KIND_RESP, ST_VIRT_BUSY, 16'hFFFF, '0, 1'b1);
                end else begin
                    id = next_id;
                    next_id++;
                    if (c.seconds == 0) begin
                        push_res(KIND_EXPIRE, ST_OK, id, '0, 1'b0);
                    end else begin
                        vt_valid = 1;
                        vt_id = id;
                        vt_rem = c.seconds;
                    end
                    push_res(KIND_RESP, ST_OK, id, '0, 1'b1);
                end
            end
            FN_CANCEL: begin
                if (vt_valid && vt_id == c.tid) begin
                    vt_valid = 0;
                    vt_rem = '0;
                    hit = 1;
                end else begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!hit && tq_valid[i] && tq_id[i] == c.tid) begin
                            drop_slot(i);
                            hit = 1;
                        end
                    end
                end
                push_res(KIND_RESP, hit ? ST_OK : ST_NOT_FOUND, '0, '0, 1'b1);
            end
            FN_QUERY: begin
                if (vt_valid && vt_id == c.tid) begin
                    rm = vt_rem;
                    hit = 1;
                end else begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!hit && tq_valid[i] && tq_id[i] == c.tid) begin
                            dl = (tq_dl[i] > now_sec) ? tq_dl[i] - now_sec : '0;
                            rm = (dl > 32'hFFFFFF) ? 24'hFFFFFF : dl[23:0];
                            hit = 1;
                        end
                    end
                end
                push_res(KIND_RESP, hit ? ST_OK : ST_NOT_FOUND, '0, rm, 1'b1);
            end
            FN_SEC_TICK: begin
                now_sec++;
                expire_due();
                push_res(KIND_RESP, ST_OK, '0, '0, 1'b1);
            end
            FN_VIRT_TICK: begin
                if (vt_valid) begin
                    vt_rem--;
                    if (vt_rem == 0) begin
                        vt_valid = 0;
                        push_res(KIND_EXPIRE, ST_OK, vt_id, '0, 1'b0);
                    end
                end
                push_res(KIND_RESP, ST_OK, '0, '0, 1'b1);
            end
            default: push_res(KIND_RESP, ST_OK, '0, '0, 1'b1);
        endcase
    endfunction

    // monitor: check results first, then model any transaction taken this edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d status=%0d id=%h rem=%h last=%0d",
                         $time, o_kind, o_status, o_result_id, o_remaining, o_last);
                errors++;
            end else begin
                res_t e;
                e = exp_q.pop_front();
                if (o_kind !== e.kind || o_status !== e.status || o_result_id !== e.rid ||
                    o_remaining !== e.rem || o_last !== e.last) begin
                    $display("%0t: mismatch exp kind=%0d status=%0d id=%h rem=%h last=%0d",
                             $time, e.kind, e.status, e.rid, e.rem, e.last);
                    $display("%0t:          act kind=%0d status=%0d id=%h rem=%h last=%0d",
                             $time, o_kind, o_status, o_result_id, o_remaining, o_last);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            cmd_t c;
            c.func = i_func; c.seconds = i_seconds; c.tid = i_timer_id; c.drain = 0;
            predict_timers(c);
            n_accepted++;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || taken)) begin
            if (cmd_q.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_q[0].drain && exp_q.size() != 0) begin
                start <= 1'b0;
            end else if ((n_accepted < 150 || n_accepted > 230) &&
                         $urandom_range(99) < 22) begin
                start <= 1'b0;
            end else begin
                cmd_t c;
                c = cmd_q.pop_front();
                start <= 1'b1;
                i_func <= c.func;
                i_seconds <= c.seconds;
                i_timer_id <= c.tid;
            end
        end
    end

    int issued = 0;

    function automatic void add(logic [2:0] f, logic [23:0] s, logic [15:0] t,
                                bit d = 0);
        cmd_t c;
        c.func = f; c.seconds = s; c.tid = t; c.drain = d;
        cmd_q.push_back(c);
        if (f == FN_SET_REAL || f == FN_SET_VIRT) issued++;
    endfunction

    function automatic logic [15:0] pick_id();
        int back;
        if ($urandom_range(9) == 0) return 16'($urandom);
        back = $urandom_range(12);
        return 16'((issued > back) ? issued - 1 - back : 0);
    endfunction

    initial begin
        int pick;
        for (int i = 0; i < NSLOT; i++) begin
            tq_valid[i] = 0; tq_id[i] = '0; tq_dl[i] = '0;
        end
        now_sec = '0; next_id = '0; vt_valid = 0; vt_id = '0; vt_rem = '0;

        add(FN_SET_REAL, 24'd0, 16'h0);
        add(FN_SET_REAL, 24'hFFFFFF, 16'hFFFF);
        add(FN_QUERY, 24'h0, 16'd1);
        add(FN_SET_REAL, 24'd2, 16'h0);
        add(FN_SET_REAL, 24'd2, 16'h0);
        add(FN_SET_REAL, 24'd1, 16'h0);
        add(FN_SEC_TICK, 24'h0, 16'h0);
        add(FN_SEC_TICK, 24'hFFFFFF, 16'hFFFF);
        add(FN_SET_VIRT, 24'd0, 16'h0);
        add(FN_SET_VIRT, 24'd2, 16'h0);
        add(FN_SET_VIRT, 24'd7, 16'h0);
        add(FN_QUERY, 24'h0, 16'd6);
        add(FN_VIRT_TICK, 24'h0, 16'h0);
        add(FN_VIRT_TICK, 24'h0, 16'h0);
        add(FN_VIRT_TICK, 24'h0, 16'h0);
        add(FN_SET_VIRT, 24'd9, 16'h0);
        add(FN_CANCEL, 24'h0, 16'd7);
        add(FN_CANCEL, 24'h0, 16'd1);
        add(FN_CANCEL, 24'h0, 16'hFFFF);
        add(FN_QUERY, 24'hFFFFFF, 16'hFFFF);
        add(3'd6, 24'h5A5A5A, 16'hA5A5);
        add(3'd7, 24'hFFFFFF, 16'hFFFF);
        // fill the table, then overflow it
        for (int i = 0; i < NSLOT + 2; i++) add(FN_SET_REAL, 24'($urandom_range(40, 3)), 16'h0);
        add(FN_QUERY, 24'h0, pick_id(), 1);

        while (cmd_q.size() < 310) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                add(FN_SET_REAL, ($urandom_range(19) == 0) ? 24'($urandom) :
                    24'($urandom_range(12)), 16'($urandom));
            end else if (pick < 40) begin
                add(FN_SET_VIRT, 24'($urandom_range(6)), 16'($urandom));
            end else if (pick < 52) begin
                add(FN_CANCEL, 24'($urandom), pick_id());
            end else if (pick < 64) begin
                add(FN_QUERY, 24'($urandom), pick_id());
            end else if (pick < 84) begin
                add(FN_SEC_TICK, 24'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                add(FN_VIRT_TICK, 24'($urandom), 16'($urandom));
            end else begin
                add(3'($urandom_range(7, 6)), 24'($urandom), 16'($urandom));
            end
            if ($urandom_range(39) == 0) cmd_q[$].drain = 1;
        end
        gen_done = 1;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (gen_done && cmd_q.size() == 0 && !start && exp_q.size() == 0);
        repeat (120) @(posedge i_clk);
        $display("Ran %0d commands: %0d expiries, %0d table-full and %0d virtual-busy replies.",
                 n_accepted, n_expiries, n_full, n_busy);
        if (errors == 0 && exp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, exp_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end
endmodule

@@ sorted_deadline_timer_queue_top.f @@
design/sdtq_pkg.sv
design/sdtq_ram.sv
design/sorted_deadline_timer_queue_top.sv
verif/tb_sorted_deadline_timer_queue_top.sv
